// ===== hw/rtl/tts_pkg.sv =====
// Package for the tap tempo step arpeggiator: shared constants, types and tables.
// Used by the divider, the top level and the testbench.
package tts_pkg;

  localparam int TAP_HISTORY_DEF    = 4;
  localparam int MAX_STEPS_DEF      = 16;
  localparam int MAX_TICKS_DEF      = 8;

  localparam int DIV_W              = 32;
  localparam int TAP_SUM_W          = 17;
  localparam int BEAT_W             = 16;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 64;

  localparam logic [31:0] MS_PER_MINUTE = 32'd60000;
  localparam logic [31:0] MAX_TAP_GAP   = 32'd5000;
  localparam logic [3:0]  TOP_CODE      = 4'd12;
  localparam logic [7:0]  SUBS_DEFAULT  = 8'd4;

  // Item modes.
  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_TAP    = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;
  localparam logic [1:0] MODE_STOP   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVALS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_SUBS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TEMPO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_TEMPO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMPO    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMPO    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LED_PULSE    = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAP_LOAD,
    S_TAP_SUM,
    S_AVG_WAIT,
    S_BPM_WAIT,
    S_BEAT_WAIT,
    S_TICK_WAIT,
    S_PHASE_WAIT,
    S_PHASE_APPLY,
    S_TICK_CHK,
    S_EMIT,
    S_CLOSE
  } state_t;

  // Request to and answer from the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Pitch command bytes for each saturated interval code.
  function automatic logic [13:0] pitch_entry(input logic [3:0] code);
    logic [13:0] e;
    unique case (code)
      4'd0:    e = {7'd25, 7'd0};
      4'd1:    e = {7'd4, 7'd25};
      4'd2:    e = {7'd4, 7'd51};
      4'd3:    e = {7'd4, 7'd76};
      4'd4:    e = {7'd4, 7'd101};
      4'd5:    e = {7'd4, 7'd127};
      4'd6:    e = {7'd3, 7'd109};
      4'd7:    e = {7'd3, 7'd127};
      4'd8:    e = {7'd2, 7'd85};
      4'd9:    e = {7'd2, 7'd95};
      4'd10:   e = {7'd2, 7'd106};
      4'd11:   e = {7'd2, 7'd116};
      default: e = {7'd2, 7'd127};
    endcase
    return e;
  endfunction

endpackage

// ===== hw/rtl/tts_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing but the port widths of the block.
interface tts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] now_ms;
  modport source (output valid, mode, now_ms, input ready);
  modport sink (input valid, mode, now_ms, output ready);
endinterface

interface tts_out_if;
  logic       valid;
  logic       ready;
  logic       is_command;
  logic [6:0] command_first;
  logic [6:0] command_second;
  logic       beat_led;
  logic       last_of_run;
  modport source (output valid, is_command, command_first, command_second, beat_led,
                  last_of_run, input ready);
  modport sink (input valid, is_command, command_first, command_second, beat_led,
                last_of_run, output ready);
endinterface

// ===== hw/rtl/tap_tempo_step_arpeggiator_unit.sv =====
// Tap tempo step arpeggiator: sequencer around one shared divider.
// Depends on tts_pkg, the channel interfaces in tts_if and tts_div.
//
// The block takes one item at a time and holds ready low until the closing
// status item of that item has been taken. Start, stop and an update while
// stopped go from the accept straight to the closing item. A tap loads the
// tap history, walks it one gap at a time and, if any gap is valid, runs two
// divisions (mean gap, then tempo) before the closing item. An update while
// playing runs three divisions on the shared 32-bit divider (beat period,
// tick period, beat phase) and the phase step, then alternates tick checks
// and command items until no tick is due and ends with the closing item;
// output stalls hold those items. The divider yields one quotient bit per cycle.
module tap_tempo_step_arpeggiator_unit #(
  parameter int TAP_HISTORY          = tts_pkg::TAP_HISTORY_DEF,
  parameter int MAX_STEPS            = tts_pkg::MAX_STEPS_DEF,
  parameter int MAX_TICKS_PER_UPDATE = tts_pkg::MAX_TICKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  tts_in_if.sink                         event_ch,
  tts_out_if.source                      result_ch,
  input  logic                           cfg_we,
  input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int GAP_W  = $clog2(TAP_HISTORY);
  localparam int CNT_W  = $clog2(TAP_HISTORY);
  localparam int TN_W   = $clog2(MAX_TICKS_PER_UPDATE + 1);

  // Configuration registers.
  logic [4:0]  step_count;
  logic [63:0] step_intervals;
  logic [7:0]  tick_subdivisions;
  logic [9:0]  initial_tempo_bpm;
  logic [9:0]  default_tempo_bpm;
  logic [9:0]  min_tempo_bpm;
  logic [9:0]  max_tempo_bpm;
  logic [15:0] led_pulse_ms;

  // Block state.
  logic [31:0]            tap_times [TAP_HISTORY];
  logic [TAP_HISTORY-1:0] tap_valid;
  logic [9:0]             tapped_tempo;
  logic [9:0]             current_tempo;
  logic                   playing;
  logic [STEP_W-1:0]      step_index;
  logic [31:0]            last_beat_ms;
  logic [31:0]            last_tick_ms;
  logic                   led_on;

  // Working registers of the sequencer.
  tts_pkg::state_t        state, state_next;
  logic [31:0]            now_r;
  logic [31:0]            scan [TAP_HISTORY];
  logic [TAP_HISTORY-1:0] scan_valid;
  logic [GAP_W-1:0]       gap_idx;
  logic [tts_pkg::TAP_SUM_W-1:0] gap_sum;
  logic [CNT_W-1:0]       gap_cnt;
  logic [tts_pkg::BEAT_W-1:0] beat;
  logic [tts_pkg::BEAT_W-1:0] tick;
  logic [31:0]            phase_prod;
  logic [TN_W-1:0]        tick_n;
  logic                   out_cmd;
  logic [6:0]             out_first;
  logic [6:0]             out_second;

  tts_pkg::div_req_t div_req;
  tts_pkg::div_rsp_t div_rsp;

  tts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Combinational helpers.
  logic        in_take, out_take, cfg_hit;
  logic [31:0] gap;
  logic        gap_ok;
  logic [tts_pkg::TAP_SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] cnt_new;
  logic        gap_last;
  logic [9:0]  tempo_sel;
  logic [7:0]  subs;
  logic        odd_count;
  logic [4:0]  steps;
  logic [31:0] beat_d;
  logic [31:0] tick_d;
  logic        tick_due;
  logic [3:0]  raw_code;
  logic [3:0]  code;
  logic [13:0] entry;
  logic [31:0] bpm_raw, bpm_lo, bpm_clamped;
  logic [STEP_W:0] step_inc;
  logic [tts_pkg::BEAT_W-1:0] tick_q;

  assign in_take  = event_ch.valid && event_ch.ready;
  assign out_take = result_ch.valid && result_ch.ready;
  assign cfg_hit  = cfg_we;

  // Gap between the two newest entries of the scan window.
  assign gap      = scan[0] - scan[1];
  assign gap_ok   = scan_valid[0] && scan_valid[1] && (gap != 32'd0) &&
                    (gap <= tts_pkg::MAX_TAP_GAP);
  assign sum_new  = gap_ok ? gap_sum + tts_pkg::TAP_SUM_W'(gap) : gap_sum;
  assign cnt_new  = gap_ok ? gap_cnt + 1'b1 : gap_cnt;
  assign gap_last = (gap_idx == GAP_W'(TAP_HISTORY - 2));

  // Tempo and sequence selection for an update.
  always_comb begin
    tempo_sel = (current_tempo != 10'd0) ? current_tempo : default_tempo_bpm;
    if (tempo_sel == 10'd0) begin
      tempo_sel = 10'd1;
    end
  end
  assign subs      = (tick_subdivisions == 8'd0) ? tts_pkg::SUBS_DEFAULT : tick_subdivisions;
  assign odd_count = (step_count == 5'd0) || (32'(step_count) > 32'(MAX_STEPS));
  assign steps     = odd_count ? 5'd1 : step_count;
  assign beat_d    = now_r - last_beat_ms;
  assign tick_d    = now_r - last_tick_ms;
  assign tick_due  = (tick_d >= 32'(tick)) && (32'(tick_n) < 32'(MAX_TICKS_PER_UPDATE));
  assign tick_q    = div_rsp.quotient[tts_pkg::BEAT_W-1:0];

  // Interval code of the current step, saturated, and its table entry.
  assign raw_code = odd_count ? 4'd0 : step_intervals[{2'b00, step_index[STEP_W-1:0]} * 4 +: 4];
  assign code     = (raw_code > tts_pkg::TOP_CODE) ? tts_pkg::TOP_CODE : raw_code;
  assign entry    = tts_pkg::pitch_entry(code);
  assign step_inc = {1'b0, step_index} + 1'b1;

  // Tapped tempo clamp: minimum first, then maximum.
  assign bpm_raw     = div_rsp.quotient;
  assign bpm_lo      = (bpm_raw < 32'(min_tempo_bpm)) ? 32'(min_tempo_bpm) : bpm_raw;
  assign bpm_clamped = (bpm_lo > 32'(max_tempo_bpm)) ? 32'(max_tempo_bpm) : bpm_lo;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and divider requests.
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state)
      tts_pkg::S_IDLE: begin
        if (in_take) begin
          if (event_ch.mode == tts_pkg::MODE_TAP) begin
            state_next = tts_pkg::S_TAP_LOAD;
          end else if (event_ch.mode == tts_pkg::MODE_UPDATE && playing) begin
            div_req.start    = 1'b1;
            div_req.dividend = tts_pkg::MS_PER_MINUTE;
            div_req.divisor  = 32'(tempo_sel);
            state_next       = tts_pkg::S_BEAT_WAIT;
          end else begin
            state_next = tts_pkg::S_CLOSE;
          end
        end
      end
      tts_pkg::S_TAP_LOAD: state_next = tts_pkg::S_TAP_SUM;
      tts_pkg::S_TAP_SUM: begin
        if (gap_last) begin
          if (cnt_new == '0) begin
            state_next = tts_pkg::S_CLOSE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = 32'(sum_new);
            div_req.divisor  = 32'(cnt_new);
            state_next       = tts_pkg::S_AVG_WAIT;
          end
        end
      end
      tts_pkg::S_AVG_WAIT: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = tts_pkg::MS_PER_MINUTE;
          div_req.divisor  = div_rsp.quotient;
          state_next       = tts_pkg::S_BPM_WAIT;
        end
      end
      tts_pkg::S_BPM_WAIT: begin
        if (div_rsp.done) begin
          state_next = tts_pkg::S_CLOSE;
        end
      end
      tts_pkg::S_BEAT_WAIT: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quotient;
          div_req.divisor  = 32'(subs);
          state_next       = tts_pkg::S_TICK_WAIT;
        end
      end
      tts_pkg::S_TICK_WAIT: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = beat_d;
          div_req.divisor  = 32'(beat);
          state_next       = tts_pkg::S_PHASE_WAIT;
        end
      end
      tts_pkg::S_PHASE_WAIT: begin
        if (div_rsp.done) begin
          state_next = tts_pkg::S_PHASE_APPLY;
        end
      end
      tts_pkg::S_PHASE_APPLY: state_next = tts_pkg::S_TICK_CHK;
      tts_pkg::S_TICK_CHK: state_next = tick_due ? tts_pkg::S_EMIT : tts_pkg::S_CLOSE;
      tts_pkg::S_EMIT: begin
        if (out_take) begin
          state_next = tts_pkg::S_TICK_CHK;
        end
      end
      tts_pkg::S_CLOSE: begin
        if (out_take) begin
          state_next = tts_pkg::S_IDLE;
        end
      end
      default: state_next = tts_pkg::S_IDLE;
    endcase
  end

  // Configuration, block state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count        <= 5'd1;
      step_intervals    <= '0;
      tick_subdivisions <= 8'd4;
      initial_tempo_bpm <= 10'd0;
      default_tempo_bpm <= 10'd120;
      min_tempo_bpm     <= 10'd30;
      max_tempo_bpm     <= 10'd300;
      led_pulse_ms      <= 16'd50;
      for (int i = 0; i < TAP_HISTORY; i++) begin
        tap_times[i] <= '0;
      end
      tap_valid     <= '0;
      tapped_tempo  <= 10'd120;
      current_tempo <= 10'd120;
      playing       <= 1'b0;
      step_index    <= '0;
      last_beat_ms  <= '0;
      last_tick_ms  <= '0;
      led_on        <= 1'b0;
    end else begin
      // Register writes; every write reloads the tempo and the step, unless a state below sets them.
      if (cfg_hit) begin
        unique case (cfg_index)
          tts_pkg::REG_STEP_COUNT: step_count        <= cfg_data[4:0];
          tts_pkg::REG_INTERVALS:  step_intervals    <= cfg_data;
          tts_pkg::REG_TICK_SUBS:  tick_subdivisions <= cfg_data[7:0];
          tts_pkg::REG_INIT_TEMPO: initial_tempo_bpm <= cfg_data[9:0];
          tts_pkg::REG_DEF_TEMPO:  default_tempo_bpm <= cfg_data[9:0];
          tts_pkg::REG_MIN_TEMPO:  min_tempo_bpm     <= cfg_data[9:0];
          tts_pkg::REG_MAX_TEMPO:  max_tempo_bpm     <= cfg_data[9:0];
          tts_pkg::REG_LED_PULSE:  led_pulse_ms      <= cfg_data[15:0];
          default: ;
        endcase
        if (cfg_index == tts_pkg::REG_INIT_TEMPO) begin
          current_tempo <= (cfg_data[9:0] == 10'd0) ? default_tempo_bpm : cfg_data[9:0];
        end else if (cfg_index == tts_pkg::REG_DEF_TEMPO) begin
          current_tempo <= (initial_tempo_bpm == 10'd0) ? cfg_data[9:0] : initial_tempo_bpm;
        end else begin
          current_tempo <= (initial_tempo_bpm == 10'd0) ? default_tempo_bpm
                                                        : initial_tempo_bpm;
        end
        step_index <= '0;
      end

      unique case (state)
        tts_pkg::S_IDLE: begin
          if (in_take) begin
            now_r <= event_ch.now_ms;
            priority case (event_ch.mode)
              tts_pkg::MODE_TAP: begin
                for (int i = TAP_HISTORY - 1; i > 0; i--) begin
                  tap_times[i] <= tap_times[i-1];
                end
                tap_times[0] <= event_ch.now_ms;
                tap_valid    <= {tap_valid[TAP_HISTORY-2:0], 1'b1};
                step_index   <= '0;
                last_beat_ms <= event_ch.now_ms;
                last_tick_ms <= event_ch.now_ms;
                led_on       <= 1'b1;
              end
              tts_pkg::MODE_START: begin
                playing      <= 1'b1;
                step_index   <= '0;
                last_beat_ms <= event_ch.now_ms;
                last_tick_ms <= event_ch.now_ms;
                led_on       <= 1'b1;
              end
              tts_pkg::MODE_STOP: begin
                playing <= 1'b0;
                led_on  <= 1'b0;
              end
              default: begin
                if (!playing) begin
                  led_on <= 1'b0;
                end
              end
            endcase
          end
        end
        tts_pkg::S_TAP_LOAD: begin
          scan       <= tap_times;
          scan_valid <= tap_valid;
          gap_idx    <= '0;
          gap_sum    <= '0;
          gap_cnt    <= '0;
        end
        tts_pkg::S_TAP_SUM: begin
          // Walk the history one gap a cycle.
          for (int i = 0; i < TAP_HISTORY - 1; i++) begin
            scan[i] <= scan[i+1];
          end
          scan_valid <= scan_valid >> 1;
          gap_idx    <= gap_idx + 1'b1;
          gap_sum    <= sum_new;
          gap_cnt    <= cnt_new;
          if (gap_last && cnt_new == '0 && tap_valid[1]) begin
            current_tempo <= tapped_tempo;
          end
        end
        tts_pkg::S_BPM_WAIT: begin
          if (div_rsp.done) begin
            tapped_tempo <= bpm_clamped[9:0];
            if (tap_valid[1]) begin
              current_tempo <= bpm_clamped[9:0];
            end
          end
        end
        tts_pkg::S_BEAT_WAIT: begin
          if (div_rsp.done) begin
            beat <= div_rsp.quotient[tts_pkg::BEAT_W-1:0];
          end
        end
        tts_pkg::S_TICK_WAIT: begin
          if (div_rsp.done) begin
            tick <= (tick_q == '0) ? tts_pkg::BEAT_W'(1) : tick_q;
          end
        end
        tts_pkg::S_PHASE_WAIT: begin
          if (div_rsp.done) begin
            phase_prod <= 32'(div_rsp.quotient * beat);
          end
        end
        tts_pkg::S_PHASE_APPLY: begin
          // Beat phase and pulse LED for this update.
          if (beat_d >= 32'(beat)) begin
            last_beat_ms <= last_beat_ms + phase_prod;
            led_on       <= 1'b1;
          end else if (beat_d >= 32'(led_pulse_ms)) begin
            led_on <= 1'b0;
          end
          tick_n <= '0;
        end
        tts_pkg::S_EMIT: begin
          if (out_take) begin
            step_index   <= (step_inc == (STEP_W+1)'(steps)) ? '0 : step_inc[STEP_W-1:0];
            last_tick_ms <= last_tick_ms + 32'(tick);
            tick_n       <= tick_n + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: loaded when the sequencer enters an emitting state.
  always_ff @(posedge clk) begin
    if (state_next == tts_pkg::S_EMIT && state == tts_pkg::S_TICK_CHK) begin
      out_cmd    <= 1'b1;
      out_first  <= entry[13:7];
      out_second <= entry[6:0];
    end else if (state_next == tts_pkg::S_CLOSE && state != tts_pkg::S_CLOSE) begin
      out_cmd    <= 1'b0;
      out_first  <= '0;
      out_second <= '0;
    end
  end

  assign event_ch.ready           = (state == tts_pkg::S_IDLE);
  assign result_ch.valid          = (state == tts_pkg::S_EMIT) || (state == tts_pkg::S_CLOSE);
  assign result_ch.is_command     = out_cmd;
  assign result_ch.command_first  = out_first;
  assign result_ch.command_second = out_second;
  assign result_ch.beat_led       = led_on;
  assign result_ch.last_of_run    = ~out_cmd;

  // No new item is taken while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> !event_ch.ready) else $error("input taken during output");
  // The command count per update stays within its bound.
  a_tick_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tts_pkg::S_EMIT) |-> (32'(tick_n) < 32'(MAX_TICKS_PER_UPDATE)))
    else $error("too many commands in one update");
  // A command item is never the closing item and is followed by another item.
  a_cmd_not_last: assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && out_cmd) |-> !result_ch.last_of_run)
    else $error("command item marked last");
  // The step index never leaves the sequence.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == tts_pkg::S_TICK_CHK) |-> (32'(step_index) < 32'(steps)))
    else $error("step index out of range");

endmodule

// ===== hw/rtl/tts_div.sv =====
// Shared iterative unsigned divider, one quotient bit per cycle.
// Depends on tts_pkg for the request and answer structs.
module tts_div (
  input  logic              clk,
  input  logic              rst,
  input  tts_pkg::div_req_t req,
  output tts_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(tts_pkg::DIV_W + 1);

  logic [tts_pkg::DIV_W-1:0] rem;
  logic [tts_pkg::DIV_W-1:0] quo;
  logic [tts_pkg::DIV_W-1:0] dvs;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;
  logic [tts_pkg::DIV_W:0]   trial;
  logic [tts_pkg::DIV_W:0]   shifted;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign shifted = {rem, quo[tts_pkg::DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(tts_pkg::DIV_W);
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!trial[tts_pkg::DIV_W]) begin
          rem <= trial[tts_pkg::DIV_W-1:0];
          quo <= {quo[tts_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted[tts_pkg::DIV_W-1:0];
          quo <= {quo[tts_pkg::DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  // A new division is only started while the unit is free.
  a_start_free: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  // The done pulse lasts one cycle and leaves the unit free.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a division");

endmodule

// ===== test/tap_tempo_step_arpeggiator_unit_test.sv =====
// Self-checking testbench for the tap tempo step arpeggiator unit.
// Depends on tts_pkg, the channel interfaces in tts_if and the unit itself.
`timescale 1ns / 1ps

module tap_tempo_step_arpeggiator_unit_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HISTORY = tts_pkg::TAP_HISTORY_DEF;
  localparam int TICK_BOUND = tts_pkg::MAX_TICKS_DEF;

  typedef struct packed {
    logic       is_command;
    logic [6:0] first;
    logic [6:0] second;
    logic       led;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now;
  } event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  tts_in_if ev ();
  tts_out_if res ();

  tap_tempo_step_arpeggiator_unit dut (
    .clk(clk), .rst(rst), .event_ch(ev), .result_ch(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Pitch bytes per saturated interval code.
  logic [6:0] pitch_hi [13] = '{25, 4, 4, 4, 4, 4, 3, 3, 2, 2, 2, 2, 2};
  logic [6:0] pitch_lo [13] = '{0, 25, 51, 76, 101, 127, 109, 127, 85, 95, 106, 116, 127};

  // Configuration and state mirrored by the predictor.
  logic [4:0]  steps_cfg;
  logic [63:0] intervals_cfg;
  logic [7:0]  subs_cfg;
  logic [9:0]  init_tempo, def_tempo, min_tempo, max_tempo;
  logic [15:0] pulse_ms;
  logic [31:0] tap_time [HISTORY];
  logic        tap_seen [HISTORY];
  logic [9:0]  tapped_bpm, tempo_now;
  logic        running, led_lit;
  logic [3:0]  step_pos;
  logic [31:0] beat_mark, tick_mark;

  event_t  pending_events[$];
  result_t expected_results[$];
  int taken_items = 0, commands_seen = 0, mismatches = 0, cycles = 0;
  logic no_idle;

  always_comb no_idle = taken_items >= 60 && taken_items < 85;

  // Register write in the mirror: every write reloads the tempo and rewinds the step.
  task automatic mirror_write(input logic [tts_pkg::CFG_IDX_W-1:0] idx,
                              input logic [63:0] val);
    case (idx)
      tts_pkg::REG_STEP_COUNT: steps_cfg = val[4:0];
      tts_pkg::REG_INTERVALS:  intervals_cfg = val;
      tts_pkg::REG_TICK_SUBS:  subs_cfg = val[7:0];
      tts_pkg::REG_INIT_TEMPO: init_tempo = val[9:0];
      tts_pkg::REG_DEF_TEMPO:  def_tempo = val[9:0];
      tts_pkg::REG_MIN_TEMPO:  min_tempo = val[9:0];
      tts_pkg::REG_MAX_TEMPO:  max_tempo = val[9:0];
      tts_pkg::REG_LED_PULSE:  pulse_ms = val[15:0];
      default: ;
    endcase
    tempo_now = (init_tempo == 0) ? def_tempo : init_tempo;
    step_pos = 0;
  endtask

  // Works out the result items for one accepted item and queues them.
  task automatic predict_results(input logic [1:0] md, input logic [31:0] now);
    logic [31:0] tempo, subs, steps, beat, tick, d, gap, sum, cnt, bpm, code;
    logic odd;
    int n;
    result_t batch[$];
    result_t r;
    n = 0;
    case (md)
      tts_pkg::MODE_TAP: begin
        for (int i = HISTORY - 1; i > 0; i--) begin
          tap_time[i] = tap_time[i-1];
          tap_seen[i] = tap_seen[i-1];
        end
        tap_time[0] = now;
        tap_seen[0] = 1'b1;
        sum = 0;
        cnt = 0;
        for (int i = 0; i + 1 < HISTORY; i++) begin
          gap = tap_time[i] - tap_time[i+1];
          if (tap_seen[i] && tap_seen[i+1] && gap != 0 && gap <= tts_pkg::MAX_TAP_GAP) begin
            sum += gap;
            cnt++;
          end
        end
        if (cnt != 0) begin
          bpm = tts_pkg::MS_PER_MINUTE / (sum / cnt);
          if (bpm < min_tempo) bpm = min_tempo;
          if (bpm > max_tempo) bpm = max_tempo;
          tapped_bpm = bpm[9:0];
        end
        if (tap_seen[1]) tempo_now = tapped_bpm;
        step_pos = 0;
        beat_mark = now;
        tick_mark = now;
        led_lit = 1'b1;
      end
      tts_pkg::MODE_START: begin
        running = 1'b1;
        step_pos = 0;
        beat_mark = now;
        tick_mark = now;
        led_lit = 1'b1;
      end
      tts_pkg::MODE_STOP: begin
        running = 1'b0;
        led_lit = 1'b0;
      end
      default: begin
        if (!running) begin
          led_lit = 1'b0;
        end else begin
          tempo = (tempo_now != 0) ? tempo_now : def_tempo;
          if (tempo == 0) tempo = 1;
          subs = (subs_cfg == 0) ? 4 : subs_cfg;
          odd = steps_cfg == 0 || steps_cfg > 16;
          steps = odd ? 1 : steps_cfg;
          beat = tts_pkg::MS_PER_MINUTE / tempo;
          tick = beat / subs;
          if (tick == 0) tick = 1;
          while (now - tick_mark >= tick && n < TICK_BOUND) begin
            code = odd ? 0 : (intervals_cfg >> (4 * ((step_pos % steps) & 15))) & 15;
            if (code > tts_pkg::TOP_CODE) code = tts_pkg::TOP_CODE;
            r = '{1'b1, pitch_hi[code], pitch_lo[code], 1'b0, 1'b0};
            batch.push_back(r);
            n++;
            step_pos = ((step_pos + 1) % steps) & 15;
            tick_mark += tick;
          end
          d = now - beat_mark;
          if (d >= beat) begin
            beat_mark += (d / beat) * beat;
            led_lit = 1'b1;
          end else if (d >= pulse_ms) begin
            led_lit = 1'b0;
          end
        end
      end
    endcase
    batch.push_back('{1'b0, 7'd0, 7'd0, 1'b0, 1'b1});
    foreach (batch[k]) begin
      batch[k].led = led_lit;
      expected_results.push_back(batch[k]);
    end
  endtask

  // Sender: offers the pending items and idles now and then.
  always @(posedge clk) begin
    if (rst) begin
      ev.valid <= 1'b0;
    end else if (!ev.valid || ev.ready) begin
      if (pending_events.size() > 0 && (no_idle || $urandom_range(99) >= 26)) begin
        ev.valid <= 1'b1;
        {ev.mode, ev.now_ms} <= pending_events.pop_front();
      end else begin
        ev.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once traffic is flowing.
  int hold_left = 0;
  logic held_once = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else if (!held_once && taken_items == 40) begin
      held_once <= 1'b1;
      hold_left <= 400;
      res.ready <= 1'b0;
    end else begin
      res.ready <= no_idle || $urandom_range(99) >= 26;
    end
  end

  // Monitor: predicts on each accepted item and checks each result item.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (ev.valid && ev.ready) begin
        predict_results(ev.mode, ev.now_ms);
        taken_items++;
      end
      if (res.valid && res.ready) begin
        got = '{res.is_command, res.command_first, res.command_second,
                res.beat_led, res.last_of_run};
        if (got.is_command) commands_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d result items outstanding", expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [tts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    mirror_write(idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_events.size() > 0 || ev.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly playing sequences with random timing, some taps, some noise.
  task automatic queue_phase(input int count, input logic [31:0] base, input int span);
    logic [31:0] t;
    int pick;
    t = base;
    pending_events.push_back('{tts_pkg::MODE_START, t});
    for (int i = 1; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        t += $urandom_range(span);
        pending_events.push_back('{tts_pkg::MODE_UPDATE, t});
      end else if (pick < 78) begin
        t += ($urandom_range(9) == 0) ? $urandom_range(9000) : $urandom_range(1500);
        pending_events.push_back('{tts_pkg::MODE_TAP, t});
      end else if (pick < 84) begin
        pending_events.push_back('{tts_pkg::MODE_STOP, t});
      end else if (pick < 90) begin
        pending_events.push_back('{tts_pkg::MODE_START, t});
      end else begin
        pending_events.push_back('{2'($urandom_range(3)), 32'($urandom)});
      end
    end
  endtask

  initial begin
    ev.valid = 1'b0;
    ev.mode = tts_pkg::MODE_UPDATE;
    ev.now_ms = '0;
    res.ready = 1'b0;
    steps_cfg = 1; intervals_cfg = 0; subs_cfg = 4; init_tempo = 0;
    def_tempo = 120; min_tempo = 30; max_tempo = 300; pulse_ms = 50;
    for (int i = 0; i < HISTORY; i++) begin
      tap_time[i] = 0;
      tap_seen[i] = 1'b0;
    end
    tapped_bpm = 120; tempo_now = 120; running = 0; led_lit = 0;
    step_pos = 0; beat_mark = 0; tick_mark = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part on reset settings: stopped update, playback, taps, extremes.
    pending_events.push_back('{tts_pkg::MODE_UPDATE, 32'd0});
    pending_events.push_back('{tts_pkg::MODE_START, 32'd1000});
    pending_events.push_back('{tts_pkg::MODE_UPDATE, 32'd1040});
    pending_events.push_back('{tts_pkg::MODE_UPDATE, 32'd1130});
    pending_events.push_back('{tts_pkg::MODE_UPDATE, 32'd1600});
    pending_events.push_back('{tts_pkg::MODE_UPDATE, 32'd3000});
    pending_events.push_back('{tts_pkg::MODE_TAP, 32'd4000});
    pending_events.push_back('{tts_pkg::MODE_TAP, 32'd4000});
    pending_events.push_back('{tts_pkg::MODE_TAP, 32'd4400});
    pending_events.push_back('{tts_pkg::MODE_TAP, 32'd4800});
    pending_events.push_back('{tts_pkg::MODE_TAP, 32'd10900});
    pending_events.push_back('{tts_pkg::MODE_TAP, 32'd10910});
    pending_events.push_back('{tts_pkg::MODE_UPDATE, 32'd11000});
    pending_events.push_back('{tts_pkg::MODE_STOP, 32'd11100});
    pending_events.push_back('{tts_pkg::MODE_UPDATE, 32'd11200});
    pending_events.push_back('{tts_pkg::MODE_START, 32'hFFFF_FF00});
    pending_events.push_back('{tts_pkg::MODE_UPDATE, 32'hFFFF_FFFF});
    pending_events.push_back('{tts_pkg::MODE_UPDATE, 32'h0000_0300});
    pending_events.push_back('{tts_pkg::MODE_TAP, 32'hFFFF_FFFF});
    pending_events.push_back('{tts_pkg::MODE_TAP, 32'h0000_01F3});
    pending_events.push_back('{tts_pkg::MODE_UPDATE, 32'h0000_0400});
    drain();

    // Full sequence with saturating codes, fastest tempo, no LED pulse.
    write_reg(tts_pkg::REG_STEP_COUNT, 64'd16);
    write_reg(tts_pkg::REG_INTERVALS, 64'hFEDC_BA98_7654_3210);
    write_reg(tts_pkg::REG_TICK_SUBS, 64'd0);
    write_reg(tts_pkg::REG_INIT_TEMPO, 64'd1000);
    write_reg(tts_pkg::REG_DEF_TEMPO, 64'd1000);
    write_reg(tts_pkg::REG_MIN_TEMPO, 64'd1);
    write_reg(tts_pkg::REG_MAX_TEMPO, 64'd1000);
    write_reg(tts_pkg::REG_LED_PULSE, 64'd0);
    end_writes();
    queue_phase(25, 32'h0000_1000, 90);
    drain();

    // Out-of-range step count, crossed clamps, finest subdivision, longest pulse.
    write_reg(tts_pkg::REG_STEP_COUNT, 64'd0);
    write_reg(tts_pkg::REG_TICK_SUBS, 64'd255);
    write_reg(tts_pkg::REG_DEF_TEMPO, 64'd1);
    write_reg(tts_pkg::REG_MIN_TEMPO, 64'd500);
    write_reg(tts_pkg::REG_MAX_TEMPO, 64'd200);
    write_reg(tts_pkg::REG_LED_PULSE, 64'd65535);
    write_reg(tts_pkg::REG_INIT_TEMPO, 64'd0);
    end_writes();
    queue_phase(22, 32'hFFFF_F000, 40);
    drain();

    // Step count above the maximum, random codes, one tick per beat.
    write_reg(tts_pkg::REG_STEP_COUNT, 64'd31);
    write_reg(tts_pkg::REG_INTERVALS, {32'($urandom), 32'($urandom)});
    write_reg(tts_pkg::REG_TICK_SUBS, 64'd1);
    write_reg(tts_pkg::REG_INIT_TEMPO, 64'd30);
    write_reg(tts_pkg::REG_MIN_TEMPO, 64'd1000);
    write_reg(tts_pkg::REG_MAX_TEMPO, 64'd1000);
    write_reg(tts_pkg::REG_LED_PULSE, 64'd1);
    end_writes();
    queue_phase(20, 32'($urandom), 3000);
    drain();

    // Mid-range settings with random intervals and a random sequence length.
    write_reg(tts_pkg::REG_STEP_COUNT, 64'($urandom_range(1, 16)));
    write_reg(tts_pkg::REG_INTERVALS, {32'($urandom), 32'($urandom)});
    write_reg(tts_pkg::REG_TICK_SUBS, 64'($urandom_range(2, 12)));
    write_reg(tts_pkg::REG_MIN_TEMPO, 64'd30);
    write_reg(tts_pkg::REG_MAX_TEMPO, 64'd600);
    write_reg(tts_pkg::REG_INIT_TEMPO, 64'($urandom_range(60, 400)));
    write_reg(tts_pkg::REG_LED_PULSE, 64'd50);
    end_writes();
    queue_phase(25, 32'($urandom), 400);
    drain();

    $display("Covered %0d items and %0d pitch commands over five register settings,",
             taken_items, commands_seen);
    $display("with taps, playback wrap-around and a long output hold-off.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== tap_tempo_step_arpeggiator_unit.f =====
hw/rtl/tts_pkg.sv
hw/rtl/tts_if.sv
hw/rtl/tts_div.sv
hw/rtl/tap_tempo_step_arpeggiator_unit.sv
test/tap_tempo_step_arpeggiator_unit_test.sv
